[rtl/lru_key_value_store_unit_macros.svh]
// ----------------------------------------------------------------------------
// lru key-value store assertion macros
// shared assertion shorthands, clocked on clk and disabled during rst_n low
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_STORE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_STORE_UNIT_MACROS_SVH

// same-cycle implication
`define LRU_KVS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRU_KVS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lru_kvs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru key-value store package
// shared widths, constants, command codes and sequencer states
// ----------------------------------------------------------------------------
package lru_kvs_pkg;

  // payload widths and default entry count
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 5;
  localparam int ENTRIES_DEF = 16;

  // capacity register after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // value returned by a get that misses
  localparam logic signed [DATA_W-1:0] READ_MISS = -32'sd1;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_SET = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

[rtl/lru_kvs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru key-value store channels
// valid/ready channels for requests, results and the capacity register
// ----------------------------------------------------------------------------

// request channel
interface lru_kvs_in_if import lru_kvs_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  cmd;
  word_t key;
  word_t value;
  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

// result channel
interface lru_kvs_out_if import lru_kvs_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  hit;
  word_t read_value;
  logic  evicted;
  word_t evicted_key;
  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

// capacity register write channel
interface lru_kvs_cfg_if import lru_kvs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/lru_kvs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru key-value store ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lru_kvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/lru_key_value_store_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru key-value store unit
// fully associative key-value store with least-recently-used replacement
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one request: cmd (get or set), key and value. out_chan
//   returns one result per request: hit, read_value, evicted, evicted_key.
//   cfg_chan is always ready and writes the capacity (0 acts as 1, above
//   ENTRIES as ENTRIES); write it only while the store is idle (not enforced).
// Sequence:
//   a request is taken in the idle state, then the keys are scanned one
//   entry per cycle through the key and value rams, whose read is
//   registered, then the update state writes the rams, ages the recency
//   ranks and loads the result register. The next request is taken only
//   after the store returns to the idle state.
// Stall:
//   the result register holds while out_chan.ready is low; the next request
//   is still taken and scanned, and only its update cycle waits for the
//   result register to drain.
// Reset:
//   rst_n (synchronous, active low) empties the store and sets the capacity
//   to 16. Key and value rams are not cleared; valid bits guard them.
// ----------------------------------------------------------------------------
`include "lru_key_value_store_unit_macros.svh"

module lru_key_value_store_unit import lru_kvs_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  lru_kvs_in_if.sink     in_chan,
  lru_kvs_out_if.source  out_chan,
  lru_kvs_cfg_if.sink    cfg_chan
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int RANK_W = IDX_W;
  localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);
  localparam logic [CNT_W-1:0] ONE_CNT     = CNT_W'(1);

  // sequencer
  state_t state_r, state_nxt;

  // scan control
  logic [CNT_W-1:0]  scan_cnt_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;

  // latched request
  cmd_t              cmd_r;
  word_t             key_r;
  word_t             val_r;

  // scan findings
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [RANK_W-1:0] hit_rank_r;
  word_t             hit_val_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic              old_found_r;
  logic [IDX_W-1:0]  old_idx_r;
  logic [RANK_W-1:0] old_rank_r;
  word_t             old_key_r;

  // entry state
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [RANK_W-1:0]  rank_r   [ENTRIES];
  logic [RANK_W-1:0]  rank_nxt [ENTRIES];
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [CAP_W-1:0]   cap_r;

  // result register
  logic  out_valid_r;
  logic  out_hit_r;
  word_t out_rd_r;
  logic  out_ev_r;
  word_t out_evk_r;

  // control outputs of the sequencer
  logic              in_ready;
  logic              in_take;
  logic              ram_re;
  logic              cmp_en;
  logic              upd_go;

  // ram ports
  logic [DATA_W-1:0] key_rd, val_rd;
  logic              key_we, val_we;

  // compare stage view of the entry
  logic              cmp_v;
  logic [RANK_W-1:0] cmp_rank;
  logic              cmp_match;

  // update decode
  logic              is_set;
  logic              do_fill;
  logic              do_evict;
  logic              touch_en;
  logic              touch_inf;
  logic [IDX_W-1:0]  touch_idx;
  logic [RANK_W-1:0] touch_rank;
  logic [CNT_W-1:0]  cap_eff;

  // effective capacity, clamped to 1 .. ENTRIES
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = ONE_CNT;
    end else if (int'(cap_r) > ENTRIES) begin
      cap_eff = ENTRIES_CNT;
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == ENTRIES_CNT) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    ram_re   = 1'b0;
    cmp_en   = 1'b0;
    upd_go   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SCAN: begin
        ram_re = (scan_cnt_r < ENTRIES_CNT);
        cmp_en = cmp_vld_r;
      end
      ST_UPDATE: begin
        upd_go = !out_valid_r || out_chan.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_chan.ready  = in_ready;
  assign in_take        = in_ready && in_chan.valid;
  assign cfg_chan.ready = 1'b1;

  // entry under compare
  assign cmp_v     = valid_r[cmp_idx_r];
  assign cmp_rank  = rank_r[cmp_idx_r];
  assign cmp_match = cmp_v && (key_rd == key_r);

  // update decode
  assign is_set     = (cmd_r == CMD_SET);
  assign do_fill    = is_set && !hit_r && (occ_r < cap_eff);
  assign do_evict   = is_set && !hit_r && !do_fill;
  assign touch_en   = hit_r || is_set;
  assign touch_inf  = do_fill;
  assign touch_idx  = hit_r ? hit_idx_r : (do_fill ? free_idx_r : old_idx_r);
  assign touch_rank = hit_r ? hit_rank_r : old_rank_r;

  // recency ageing and slot fill
  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (upd_go && touch_en) begin
        if (IDX_W'(i) == touch_idx) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (touch_inf || rank_r[i] < touch_rank)) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end
    end
    if (upd_go && do_fill) begin
      valid_nxt[free_idx_r] = 1'b1;
      occ_nxt               = occ_r + ONE_CNT;
    end
  end

  assign key_we = upd_go && is_set && !hit_r;
  assign val_we = upd_go && is_set;

  // key and value stores
  lru_kvs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (touch_idx),
    .wdata (key_r),
    .re    (ram_re),
    .raddr (scan_cnt_r[IDX_W-1:0]),
    .rdata (key_rd)
  );

  lru_kvs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (touch_idx),
    .wdata (val_r),
    .re    (ram_re),
    .raddr (scan_cnt_r[IDX_W-1:0]),
    .rdata (val_rd)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_cnt_r   <= '0;
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      old_found_r  <= 1'b0;
      valid_r      <= '0;
      rank_r       <= '{default: '0};
      occ_r        <= '0;
      cap_r        <= CAP_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      occ_r   <= occ_nxt;
      if (cfg_chan.valid) begin
        cap_r <= cfg_chan.data;
      end
      // start of a request
      if (in_take) begin
        scan_cnt_r   <= '0;
        cmp_vld_r    <= 1'b0;
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
        old_found_r  <= 1'b0;
      end
      // scan issue
      if (state_r == ST_SCAN) begin
        cmp_vld_r <= ram_re;
        if (ram_re) begin
          scan_cnt_r <= scan_cnt_r + ONE_CNT;
        end
      end
      // scan compare flags
      if (cmp_en) begin
        if (cmp_match && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (!cmp_v && !free_found_r) begin
          free_found_r <= 1'b1;
        end
        if (cmp_v && (!old_found_r || cmp_rank > old_rank_r)) begin
          old_found_r <= 1'b1;
        end
      end
      // result handshake
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r <= cmd_t'(in_chan.cmd);
      key_r <= in_chan.key;
      val_r <= in_chan.value;
    end
    if (ram_re) begin
      cmp_idx_r <= scan_cnt_r[IDX_W-1:0];
    end
    if (cmp_en) begin
      if (cmp_match && !hit_r) begin
        hit_idx_r  <= cmp_idx_r;
        hit_rank_r <= cmp_rank;
        hit_val_r  <= val_rd;
      end
      if (!cmp_v && !free_found_r) begin
        free_idx_r <= cmp_idx_r;
      end
      if (cmp_v && (!old_found_r || cmp_rank > old_rank_r)) begin
        old_idx_r  <= cmp_idx_r;
        old_rank_r <= cmp_rank;
        old_key_r  <= key_rd;
      end
    end
    // result load
    if (upd_go) begin
      out_hit_r <= hit_r;
      out_ev_r  <= do_evict;
      out_evk_r <= do_evict ? old_key_r : '0;
      if (is_set) begin
        out_rd_r <= '0;
      end else if (hit_r) begin
        out_rd_r <= hit_val_r;
      end else begin
        out_rd_r <= READ_MISS;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.hit         = out_hit_r;
  assign out_chan.read_value  = out_rd_r;
  assign out_chan.evicted     = out_ev_r;
  assign out_chan.evicted_key = out_evk_r;

  // checks
  `LRU_KVS_ASSERT_IMP(a_occ_matches_valid, 1'b1, $countones(valid_r) == int'(occ_r), "occupancy differs from valid bits")
  `LRU_KVS_ASSERT_IMP(a_evict_has_victim, upd_go && do_evict, old_found_r, "eviction without a valid victim")
  `LRU_KVS_ASSERT_IMP(a_fill_has_slot, upd_go && do_fill, free_found_r, "fill without a free slot")
  `LRU_KVS_ASSERT_NXT(a_accept_starts_scan, in_take, state_r == ST_SCAN, "request taken without scan")
  `LRU_KVS_ASSERT_IMP(a_result_from_update, $rose(out_valid_r), $past(state_r) == ST_UPDATE, "result outside update")

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru key-value store unit testbench
// a short table of directed requests and capacity writes is run first, then
// random phases, each under its own capacity and key pool. every accepted
// request is replayed on a shadow lru store to predict its result, and each
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb import lru_kvs_pkg::*; ();

  localparam int ENTRIES       = ENTRIES_DEF;
  localparam int MAX_GAP       = 18;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = ENTRIES + 8;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 100;
  localparam int POOL_MAX      = 24;
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct packed {
    logic  hit;
    word_t read_value;
    logic  evicted;
    word_t evicted_key;
  } kvs_result_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CAP
  } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    cmd_t             cmd;
    word_t            key;
    word_t            value;
    logic [CAP_W-1:0] cap;
    bit               known;
    kvs_result_t      want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  lru_kvs_in_if  in_ch  ();
  lru_kvs_out_if out_ch ();
  lru_kvs_cfg_if cfg_ch ();

  lru_key_value_store_unit #(
    .ENTRIES (ENTRIES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_chan (cfg_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the store
  logic [DATA_W-1:0] shadow_key  [ENTRIES];
  logic [DATA_W-1:0] shadow_val  [ENTRIES];
  bit                shadow_live [ENTRIES];
  int unsigned       shadow_rank [ENTRIES];
  int unsigned       shadow_fill;
  logic [CAP_W-1:0]  shadow_cap;

  kvs_result_t pending_results[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          src_quiet   = 1'b0;
  bit          sink_quiet  = 1'b0;
  bit          long_hold_req = 1'b0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // make a slot the most recent; entries younger than it age by one
  function automatic void promote(input int slot);
    int unsigned old_rank;
    old_rank = shadow_live[slot] ? shadow_rank[slot] : 32'hFFFF_FFFF;
    for (int i = 0; i < ENTRIES; i++)
      if (i != slot && shadow_live[i] && shadow_rank[i] < old_rank) shadow_rank[i]++;
    shadow_rank[slot] = 0;
  endfunction

  function automatic int lookup_slot(input word_t k);
    for (int i = 0; i < ENTRIES; i++)
      if (shadow_live[i] && shadow_key[i] == k) return i;
    return -1;
  endfunction

  // predicted result of one request, updating the shadow store
  function automatic kvs_result_t predict_access(input cmd_t c, input word_t k,
                                                 input word_t v);
    kvs_result_t res;
    int          slot;
    int unsigned lim;
    int unsigned oldest;
    bit          found;
    res = '0;
    lim = 32'(shadow_cap);
    if (lim < 1) lim = 1;
    if (lim > ENTRIES) lim = ENTRIES;
    slot = lookup_slot(k);
    if (c == CMD_GET) begin
      if (slot >= 0) begin
        res.hit        = 1'b1;
        res.read_value = shadow_val[slot];
        promote(slot);
      end else begin
        res.read_value = READ_MISS;
      end
    end else if (slot >= 0) begin
      res.hit         = 1'b1;
      shadow_val[slot] = v;
      promote(slot);
    end else begin
      slot = 0;
      if (shadow_fill < lim) begin
        // lowest free slot
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!shadow_live[i]) slot = i;
        promote(slot);
        shadow_live[slot] = 1'b1;
        shadow_fill++;
      end else begin
        // oldest live entry goes
        found  = 1'b0;
        oldest = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (shadow_live[i] && (!found || shadow_rank[i] > oldest)) begin
            oldest = shadow_rank[i];
            slot   = i;
            found  = 1'b1;
          end
        end
        res.evicted     = 1'b1;
        res.evicted_key = shadow_key[slot];
        promote(slot);
      end
      shadow_key[slot] = k;
      shadow_val[slot] = v;
    end
    return res;
  endfunction

  function automatic script_row_t req_row(input cmd_t c, input word_t k, input word_t v);
    script_row_t row;
    row.kind  = ROW_REQ;
    row.cmd   = c;
    row.key   = k;
    row.value = v;
    row.cap   = '0;
    row.known = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic script_row_t req_known(input cmd_t c, input word_t k, input word_t v,
                                            input int h, input word_t rd,
                                            input int ev, input word_t evk);
    script_row_t row;
    row                  = req_row(c, k, v);
    row.known            = 1'b1;
    row.want.hit         = (h != 0);
    row.want.read_value  = rd;
    row.want.evicted     = (ev != 0);
    row.want.evicted_key = evk;
    return row;
  endfunction

  function automatic script_row_t cap_row(input logic [CAP_W-1:0] cap);
    script_row_t row;
    row      = req_row(CMD_GET, '0, '0);
    row.kind = ROW_CAP;
    row.cap  = cap;
    return row;
  endfunction

  // offer one request and record its expected result once accepted
  task automatic issue_request(input cmd_t c, input word_t k, input word_t v,
                               input bit known, input kvs_result_t want);
    int          gap;
    kvs_result_t model_res;
    gap = src_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= c;
    in_ch.key   <= k;
    in_ch.value <= v;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    model_res = predict_access(c, k, v);
    pending_results.push_back(known ? want : model_res);
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain_store();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_store();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cap;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    shadow_cap = cap;
  endtask

  // run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold on request, field checks
  initial begin
    int          stall;
    kvs_result_t want;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = sink_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall         = LONG_HOLD;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf(
          "result with no request outstanding: hit=%0b rd=%h ev=%0b evk=%h",
          out_ch.hit, out_ch.read_value, out_ch.evicted, out_ch.evicted_key));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.hit !== want.hit)
          report_mismatch($sformatf("hit %b, expected %b", out_ch.hit, want.hit));
        if (out_ch.read_value !== want.read_value)
          report_mismatch($sformatf("read_value %h, expected %h",
                                    out_ch.read_value, want.read_value));
        if (out_ch.evicted !== want.evicted)
          report_mismatch($sformatf("evicted %b, expected %b", out_ch.evicted, want.evicted));
        if (out_ch.evicted_key !== want.evicted_key)
          report_mismatch($sformatf("evicted_key %h, expected %h",
                                    out_ch.evicted_key, want.evicted_key));
      end
    end
  end

  // request side: reset, directed table, random phases, final drain
  initial begin
    script_row_t      script[$];
    word_t            key_pool [POOL_MAX];
    int               pool_size;
    logic [CAP_W-1:0] phase_cap;
    cmd_t             c;
    word_t            k;

    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= CMD_GET;
    in_ch.key    <= '0;
    in_ch.value  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;

    // shadow store after reset
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_key[i]  = '0;
      shadow_val[i]  = '0;
      shadow_live[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    shadow_fill = 0;
    shadow_cap  = CAP_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, key and value extremes, refresh of a present key
    script.push_back(req_known(CMD_GET, 32'h0000_0000, 32'h0000_0000, 0, READ_MISS, 0, 0));
    script.push_back(req_known(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
    script.push_back(req_known(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0));
    script.push_back(req_known(CMD_GET, 32'h8000_0000, 32'h0000_0000, 1, 32'h7FFF_FFFF, 0, 0));
    script.push_back(req_known(CMD_SET, 32'h8000_0000, 32'hFFFF_FFFF, 1, 0, 0, 0));
    script.push_back(req_known(CMD_GET, 32'h8000_0000, 32'h1234_5678, 1, 32'hFFFF_FFFF, 0, 0));
    script.push_back(req_known(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 32'h8000_0000, 0, 0));
    script.push_back(req_known(CMD_SET, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0));
    script.push_back(req_known(CMD_SET, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0, 0));
    // capacity lowered below occupancy: new keys replace the oldest
    script.push_back(cap_row(5'd2));
    script.push_back(req_row(CMD_SET, 32'h0000_1234, 32'h0000_0005));
    script.push_back(req_known(CMD_GET, 32'h8000_0000, 32'h0000_0000, 0, READ_MISS, 0, 0));
    script.push_back(req_row(CMD_GET, 32'h0000_0000, 32'h0000_0000));
    script.push_back(req_row(CMD_SET, 32'h0000_0055, 32'hAAAA_AAAA));
    // zero capacity acts as one
    script.push_back(cap_row(5'd0));
    script.push_back(req_row(CMD_SET, 32'h0000_0066, 32'h5555_5555));
    script.push_back(req_row(CMD_GET, 32'h0000_0066, 32'h0000_0000));
    script.push_back(req_row(CMD_SET, 32'h0000_0066, 32'h0000_0000));
    // capacity above the entry count acts as the entry count
    script.push_back(cap_row(5'd31));
    script.push_back(req_row(CMD_SET, 32'hDEAD_BEEF, 32'h1234_5678));
    script.push_back(req_row(CMD_GET, 32'hDEAD_BEEF, 32'h0000_0000));
    script.push_back(cap_row(5'd1));
    script.push_back(req_row(CMD_SET, 32'h0000_0001, 32'h0000_0002));
    script.push_back(cap_row(5'd16));
    script.push_back(req_row(CMD_GET, 32'h0000_0001, 32'h0000_0000));

    foreach (script[i]) begin
      if (script[i].kind == ROW_CAP)
        write_capacity(script[i].cap);
      else
        issue_request(script[i].cmd, script[i].key, script[i].value,
                      script[i].known, script[i].want);
    end

    // random phases: a small key pool keeps hits, refreshes and evictions frequent
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_cap = 5'd16;
        1:       phase_cap = 5'd1;
        2:       phase_cap = 5'd0;
        3:       phase_cap = 5'd31;
        4:       phase_cap = 5'd4;
        5:       phase_cap = 5'd2;
        6:       phase_cap = 5'd17;
        7:       phase_cap = 5'd8;
        default: phase_cap = CAP_W'($urandom_range(0, 31));
      endcase
      write_capacity(phase_cap);
      src_quiet  = (p % 4 == 1) || (p % 4 == 3);
      sink_quiet = (p % 4 == 2) || (p % 4 == 3);
      pool_size  = $urandom_range(2, POOL_MAX);
      for (int i = 0; i < POOL_MAX; i++) begin
        case (i)
          0:       key_pool[i] = 32'h8000_0000;
          1:       key_pool[i] = 32'h7FFF_FFFF;
          2:       key_pool[i] = 32'h0000_0000;
          3:       key_pool[i] = 32'hFFFF_FFFF;
          default: key_pool[i] = $urandom();
        endcase
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // result side holds off while requests keep coming
        if (p == 3 && n == 20) long_hold_req = 1'b1;
        // pause until the store has answered everything
        if (p == 5 && n == 50) drain_store();
        c = ($urandom_range(0, 1) != 0) ? CMD_SET : CMD_GET;
        k = ($urandom_range(0, 9) == 0) ? word_t'($urandom())
                                        : key_pool[$urandom_range(0, pool_size - 1)];
        issue_request(c, k, $urandom(), 1'b0, '0);
      end
    end

    drain_store();
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/lru_kvs_pkg.sv
rtl/lru_kvs_if.sv
rtl/lru_kvs_ram.sv
rtl/lru_key_value_store_unit.sv
verif/tb.sv
